@@ src/bilinear_texture_sampler_defines.svh @@
// Assertion helpers shared by the texture sampler RTL.
// Each helper expects clk and arst_n in scope.
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bts_pkg.sv @@
`default_nettype none

package bts_pkg;

	// Payload widths
	localparam int TEXEL_INDEX_W = 16;
	localparam int CHAN_W        = 8;
	localparam int TEXEL_W       = 3 * CHAN_W;
	localparam int COORD_W       = 18;
	localparam int CFG_DATA_W    = 9;
	localparam int CFG_IDX_W     = 1;

	// Default sizing
	localparam int MAX_SIDE_DEF    = 256;
	localparam int TEXEL_DEPTH_DEF = 65536;

	// Register indexes and reset value
	localparam logic [CFG_IDX_W-1:0]  CFG_WIDTH_IDX  = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  CFG_HEIGHT_IDX = 1'b1;
	localparam logic [CFG_DATA_W-1:0] CFG_RESET      = 9'd256;

	// Action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Fixed point: 1.0 is 2^16
	localparam int                 FRAC_W     = 16;
	localparam int                 CLAMP_W    = FRAC_W + 1;
	localparam logic [CLAMP_W-1:0] ONE_FIX    = 17'h10000;
	localparam int                 SIDE_CMP_W = 11;
	localparam int                 DEPTH_CMP_W = 21;

	// Blend widths: row blend fits 24 bits, full blend 40 bits
	localparam int               ROW_W      = CHAN_W + FRAC_W;
	localparam int               ACC_W      = CHAN_W + 2 * FRAC_W;
	localparam logic [ACC_W-1:0] ROUND_HALF = 40'h0080000000;

	// Shared multiply-add unit: q = a * b + c
	localparam int MAC_A_W = 17;
	localparam int MAC_B_W = 27;
	localparam int MAC_C_W = 42;
	localparam int MAC_P_W = 44;

endpackage

`default_nettype wire

@@ src/bts_if.sv @@
`default_nettype none

// Input beat channel: texel writes and sample requests
interface bts_item_if;
	import bts_pkg::*;

	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [TEXEL_INDEX_W-1:0]        texel_index;
	logic [CHAN_W-1:0]               red_in;
	logic [CHAN_W-1:0]               green_in;
	logic [CHAN_W-1:0]               blue_in;
	logic signed [COORD_W-1:0]       u_coord;
	logic signed [COORD_W-1:0]       v_coord;

	modport source (
		output valid, action, texel_index, red_in, green_in, blue_in, u_coord, v_coord,
		input  ready
	);
	modport sink (
		input  valid, action, texel_index, red_in, green_in, blue_in, u_coord, v_coord,
		output ready
	);
endinterface

// Result beat channel: filtered color
interface bts_result_if;
	import bts_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// Register write channel
interface bts_cfg_if;
	import bts_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/bilinear_texture_sampler.sv @@
// Write beat: the texel is stored at the accepting edge when its index is below TEXEL_DEPTH; the next beat may follow.
// Sample beat: no new beat is taken until the result is loaded into the output register; ready
//   returns as the new result is presented, and each store read waits for its address wrap.
// Sampling uses the one shared multiply-add unit (12 passes, 3 for coordinate setup
//   and 3 per channel) and the single-port texel store (4 reads); a held result adds stalls.
// Reset: sequencer idle, no result pending, both sides 256; store content undefined until written.
`default_nettype none
`include "bilinear_texture_sampler_defines.svh"

module bilinear_texture_sampler #(
	parameter int MAX_SIDE    = bts_pkg::MAX_SIDE_DEF,
	parameter int TEXEL_DEPTH = bts_pkg::TEXEL_DEPTH_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	bts_item_if.sink     item,
	bts_result_if.source result,
	bts_cfg_if.sink      cfg
);
	import bts_pkg::*;

	localparam int XW  = $clog2(MAX_SIDE);
	localparam int SW  = $clog2(MAX_SIDE + 1);
	localparam int LAW = 2 * XW;
	localparam int AW  = $clog2(TEXEL_DEPTH);

	typedef logic [1:0] ch_t;
	localparam ch_t CH_RED   = 2'd0;
	localparam ch_t CH_GREEN = 2'd1;
	localparam ch_t CH_BLUE  = 2'd2;
	localparam logic [1:0] K_LAST = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PX,
		ST_PY,
		ST_BASE,
		ST_LOAD,
		ST_WSTART,
		ST_WWAIT,
		ST_WDATA,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [1:0]              k_q;
	ch_t                     ch_q;
	logic                    out_valid_q;
	logic [CFG_DATA_W-1:0]   cfg_w_q;
	logic [CFG_DATA_W-1:0]   cfg_h_q;

	logic [CLAMP_W-1:0]      cu_q;
	logic [CLAMP_W-1:0]      cv_q;
	logic [FRAC_W-1:0]       fx_q;
	logic [FRAC_W-1:0]       fy_q;
	logic [XW-1:0]           x0_q;
	logic [LAW-1:0]          base_q;
	logic [TEXEL_W-1:0]      tex0_q;
	logic [TEXEL_W-1:0]      tex1_q;
	logic [TEXEL_W-1:0]      tex2_q;
	logic [TEXEL_W-1:0]      tex3_q;
	logic [ROW_W-1:0]        r0_q;
	logic [CHAN_W-1:0]       red_q;
	logic [CHAN_W-1:0]       green_q;
	logic [CHAN_W-1:0]       blue_q;
	logic [CHAN_W-1:0]       out_red_q;
	logic [CHAN_W-1:0]       out_green_q;
	logic [CHAN_W-1:0]       out_blue_q;

	logic                    item_acc;
	logic                    cfg_acc;
	logic                    load_out;
	logic [SW-1:0]           side_w;
	logic [SW-1:0]           side_h;
	logic [LAW-1:0]          lin;
	logic                    wrap_done;
	logic [AW-1:0]           wrap_addr;
	logic                    ram_en;
	logic                    ram_we;
	logic [AW-1:0]           ram_addr;
	logic [TEXEL_W-1:0]      ram_rdata;
	logic [CHAN_W-1:0]       t0c;
	logic [CHAN_W-1:0]       t1c;
	logic [CHAN_W-1:0]       t2c;
	logic [CHAN_W-1:0]       t3c;
	logic signed [CHAN_W:0]  d_lo;
	logic signed [CHAN_W:0]  d_hi;
	logic [ACC_W-1:0]        rnd;
	logic [MAC_A_W-1:0]        mac_a;
	logic signed [MAC_B_W-1:0] mac_b;
	logic signed [MAC_C_W-1:0] mac_c;
	logic signed [MAC_P_W-1:0] mac_q;

	function automatic logic [SW-1:0] eff_side(input logic [CFG_DATA_W-1:0] s);
		logic [SIDE_CMP_W-1:0] e;
		begin
			e = SIDE_CMP_W'(s);
			if (s == '0) begin
				e = SIDE_CMP_W'(1);
			end else if (e > SIDE_CMP_W'(MAX_SIDE)) begin
				e = SIDE_CMP_W'(MAX_SIDE);
			end
			return SW'(e);
		end
	endfunction

	function automatic logic [CLAMP_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
		if (c[COORD_W-1]) begin
			return '0;
		end else if (c[CLAMP_W-1:0] > ONE_FIX) begin
			return ONE_FIX;
		end else begin
			return c[CLAMP_W-1:0];
		end
	endfunction

	function automatic logic [CHAN_W-1:0] chan_sel(input logic [TEXEL_W-1:0] t, input ch_t ch);
		case (ch)
			CH_RED:   return t[3*CHAN_W-1 -: CHAN_W];
			CH_GREEN: return t[2*CHAN_W-1 -: CHAN_W];
			default:  return t[CHAN_W-1:0];
		endcase
	endfunction

	// Handshakes
	assign item.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign item_acc     = item.valid && item.ready;
	assign cfg_acc      = cfg.valid && cfg.ready;
	assign load_out     = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign result.valid     = out_valid_q;
	assign result.red_out   = out_red_q;
	assign result.green_out = out_green_q;
	assign result.blue_out  = out_blue_q;

	// Effective texture sides
	assign side_w = eff_side(cfg_w_q);
	assign side_h = eff_side(cfg_h_q);

	// Linear address of neighbor k: step right when fx is nonzero, down when fy is nonzero
	assign lin = base_q
		+ ((k_q[0] && (fx_q != '0)) ? LAW'(1) : '0)
		+ ((k_q[1] && (fy_q != '0)) ? LAW'(side_w) : '0);

	// Channel bytes of the four neighbors
	assign t0c  = chan_sel(tex0_q, ch_q);
	assign t1c  = chan_sel(tex1_q, ch_q);
	assign t2c  = chan_sel(tex2_q, ch_q);
	assign t3c  = chan_sel(tex3_q, ch_q);
	assign d_lo = $signed({1'b0, t1c}) - $signed({1'b0, t0c});
	assign d_hi = $signed({1'b0, t3c}) - $signed({1'b0, t2c});
	assign rnd  = mac_q[ACC_W-1:0] + ROUND_HALF;

	// Operand select for the shared multiply-add
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		case (state_q)
			ST_PX: begin
				mac_a = cu_q;
				mac_b = MAC_B_W'(side_w - 1'b1);
			end
			ST_PY: begin
				mac_a = cv_q;
				mac_b = MAC_B_W'(side_h - 1'b1);
			end
			ST_BASE: begin
				mac_a = MAC_A_W'(mac_q[FRAC_W +: XW]);
				mac_b = MAC_B_W'(side_w);
				mac_c = MAC_C_W'(x0_q);
			end
			ST_B0: begin
				mac_a = {1'b0, fx_q};
				mac_b = MAC_B_W'(d_lo);
				mac_c = MAC_C_W'({t0c, {FRAC_W{1'b0}}});
			end
			ST_B1: begin
				mac_a = {1'b0, fx_q};
				mac_b = MAC_B_W'(d_hi);
				mac_c = MAC_C_W'({t2c, {FRAC_W{1'b0}}});
			end
			ST_B2: begin
				mac_a = {1'b0, fy_q};
				mac_b = $signed(MAC_B_W'(mac_q[ROW_W-1:0])) - $signed(MAC_B_W'(r0_q));
				mac_c = MAC_C_W'({r0_q, {FRAC_W{1'b0}}});
			end
			default: begin
			end
		endcase
	end

	// Store port: writes from the input beat, reads during the wrap wait
	assign ram_we   = (state_q == ST_IDLE);
	assign ram_en   = (item_acc && (item.action == ACT_WRITE)
		&& (DEPTH_CMP_W'(item.texel_index) < DEPTH_CMP_W'(TEXEL_DEPTH)))
		|| ((state_q == ST_WWAIT) && wrap_done);
	assign ram_addr = (state_q == ST_IDLE) ? AW'(item.texel_index) : wrap_addr;

	bts_mac u_mac (
		.clk (clk),
		.a   (mac_a),
		.b   (mac_b),
		.c   (mac_c),
		.q   (mac_q)
	);

	bts_addr_wrap #(
		.LIN_W       (LAW),
		.TEXEL_DEPTH (TEXEL_DEPTH)
	) u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_WSTART),
		.lin    (lin),
		.done   (wrap_done),
		.addr   (wrap_addr)
	);

	bts_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (TEXEL_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({item.red_in, item.green_in, item.blue_in}),
		.rdata (ram_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_RESET;
			cfg_h_q <= CFG_RESET;
		end else if (cfg_acc) begin
			case (cfg.index)
				CFG_WIDTH_IDX:  cfg_w_q <= cfg.data;
				CFG_HEIGHT_IDX: cfg_h_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			ch_q        <= CH_RED;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result when the blend lands, drop it once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.action == ACT_SAMPLE)) begin
						state_q <= ST_PX;
					end
				end
				ST_PX:   state_q <= ST_PY;
				ST_PY:   state_q <= ST_BASE;
				ST_BASE: state_q <= ST_LOAD;
				ST_LOAD: begin
					k_q     <= '0;
					state_q <= ST_WSTART;
				end
				ST_WSTART: state_q <= ST_WWAIT;
				ST_WWAIT: begin
					if (wrap_done) begin
						state_q <= ST_WDATA;
					end
				end
				ST_WDATA: begin
					if (k_q == K_LAST) begin
						ch_q    <= CH_RED;
						state_q <= ST_B0;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_WSTART;
					end
				end
				ST_B0: state_q <= ST_B1;
				ST_B1: state_q <= ST_B2;
				ST_B2: state_q <= ST_B3;
				ST_B3: begin
					if (ch_q == CH_BLUE) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_B0;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_acc && (item.action == ACT_SAMPLE)) begin
			cu_q <= clamp_coord(item.u_coord);
			cv_q <= clamp_coord(item.v_coord);
		end
		if (state_q == ST_PY) begin
			fx_q <= mac_q[FRAC_W-1:0];
			x0_q <= mac_q[FRAC_W +: XW];
		end
		if (state_q == ST_BASE) begin
			fy_q <= mac_q[FRAC_W-1:0];
		end
		if (state_q == ST_LOAD) begin
			base_q <= mac_q[LAW-1:0];
		end
		if (state_q == ST_WDATA) begin
			case (k_q)
				2'd0:    tex0_q <= ram_rdata;
				2'd1:    tex1_q <= ram_rdata;
				2'd2:    tex2_q <= ram_rdata;
				default: tex3_q <= ram_rdata;
			endcase
		end
		if (state_q == ST_B1) begin
			r0_q <= mac_q[ROW_W-1:0];
		end
		if (state_q == ST_B3) begin
			case (ch_q)
				CH_RED:   red_q   <= rnd[ACC_W-1 -: CHAN_W];
				CH_GREEN: green_q <= rnd[ACC_W-1 -: CHAN_W];
				default:  blue_q  <= rnd[ACC_W-1 -: CHAN_W];
			endcase
		end
		if (load_out) begin
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
		end
	end

	// Checks
	`BTS_ASSERT_NOW(a_wrap_done_in_wait, wrap_done, state_q == ST_WWAIT, "wrap done outside wait")
	`BTS_ASSERT_NOW(a_result_from_done, $rose(result.valid), $past(state_q == ST_DONE), "result without blend")
	`BTS_ASSERT_NEXT(a_sample_starts, item_acc && (item.action == ACT_SAMPLE), state_q == ST_PX, "sample not started")
	`BTS_ASSERT_NOW(a_store_access, ram_en, (state_q == ST_IDLE) || (state_q == ST_WWAIT), "store access out of turn")

endmodule

`default_nettype wire

@@ src/bts_ram.sv @@
`default_nettype none

module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Single port: write, or read with registered data
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bts_mac.sv @@
`default_nettype none

module bts_mac (
	input  wire logic                               clk,
	input  wire logic        [bts_pkg::MAC_A_W-1:0] a,
	input  wire logic signed [bts_pkg::MAC_B_W-1:0] b,
	input  wire logic signed [bts_pkg::MAC_C_W-1:0] c,
	output logic signed      [bts_pkg::MAC_P_W-1:0] q
);
	import bts_pkg::*;

	logic signed [MAC_P_W-1:0] prod;
	logic signed [MAC_P_W-1:0] sum;

	// Multiply unsigned a by signed b, add c
	always_comb begin
		prod = $signed({1'b0, a}) * b;
		sum  = prod + MAC_P_W'(c);
	end

	// Register the result every cycle
	always_ff @(posedge clk) begin
		q <= sum;
	end

endmodule

`default_nettype wire

@@ src/bts_addr_wrap.sv @@
`default_nettype none

module bts_addr_wrap #(
	parameter int LIN_W       = 16,
	parameter int TEXEL_DEPTH = 65536
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [LIN_W-1:0]               lin,
	output logic                                done,
	output logic      [$clog2(TEXEL_DEPTH)-1:0] addr
);

	localparam int AW = $clog2(TEXEL_DEPTH);
	localparam bit WRAP_FREE = ((1 << AW) == TEXEL_DEPTH) || ((1 << LIN_W) <= TEXEL_DEPTH);

	if (WRAP_FREE) begin : g_direct
		logic          done_q;
		logic [AW-1:0] addr_q;

		// Power-of-two depth or no overflow: truncate
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			addr_q <= AW'(lin);
		end

		assign done = done_q;
		assign addr = addr_q;
	end else begin : g_iter
		localparam int STEPS = LIN_W - AW + 2;
		localparam int RW    = LIN_W + 1;
		localparam int STW   = $clog2(STEPS);

		logic [RW-1:0]  r_q;
		logic [RW-1:0]  sh;
		logic [RW-1:0]  r_nxt;
		logic [STW-1:0] step_q;
		logic           busy_q;
		logic           done_q;

		// One restoring step: subtract depth shifted by the step count
		always_comb begin
			sh    = RW'(TEXEL_DEPTH) << step_q;
			r_nxt = (r_q >= sh) ? (r_q - sh) : r_q;
		end

		// Step sequencing
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				step_q <= '0;
			end else if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= STW'(STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end

		// Remainder register
		always_ff @(posedge clk) begin
			if (start) begin
				r_q <= RW'(lin);
			end else if (busy_q) begin
				r_q <= r_nxt;
			end
		end

		assign done = done_q;
		assign addr = AW'(r_q);
	end

endmodule

`default_nettype wire
